@@ design/rpa_pkg.sv @@
`timescale 1ns / 1ps

package rpa_pkg;

    // Longest run that one allocate-run request may ask for
    localparam int unsigned MAX_RUN = 8;

    localparam int unsigned NUM_REGS = 32;
    localparam int unsigned SAVED_W  = 10;

    // Scratch pool 9..15, callee-saved pool 19..28
    localparam logic [5:0] POOL1_LO  = 6'd9;
    localparam logic [5:0] POOL1_END = 6'd16;
    localparam logic [5:0] POOL2_LO  = 6'd19;
    localparam logic [5:0] POOL2_END = 6'd29;

    localparam logic [NUM_REGS-1:0] POOL1_MASK = 32'h0000_FE00;
    localparam logic [NUM_REGS-1:0] POOL2_MASK = 32'h1FF8_0000;
    localparam logic [NUM_REGS-1:0] POOL_MASK  = POOL1_MASK | POOL2_MASK;

    typedef enum logic [1:0] {
        OP_ALLOC_ONE   = 2'd0,
        OP_ALLOC_RUN   = 2'd1,
        OP_RELEASE     = 2'd2,
        OP_RELEASE_ALL = 2'd3
    } opcode_t;

    typedef struct packed {
        logic [4:0] release_reg;
        logic [3:0] run_length;
        opcode_t    opcode;
    } request_t;

    typedef struct packed {
        logic [SAVED_W-1:0] saved_mask;
        logic [5:0]         end_reg;
        logic [4:0]         first_reg;
        logic               status;
    } result_t;

endpackage

@@ design/register_pool_allocator_top.sv @@
`timescale 1ns / 1ps
// Pipeline: input register, then result register, with the bitmap search between the two;
//   m_tvalid comes from the result register.
// Throughput: one transaction per cycle while m_tready keeps the result stage free;
//   the busy map is updated at the same edge the result is registered, so back-to-back
//   requests see each other's effect. Reset: synchronous active-low aresetn empties both
//   stages and clears the busy map and the callee-saved marks.
module register_pool_allocator_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [1:0] opcode, [5:2] run_length, [10:6] release_reg
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [0] status, [5:1] first_reg, [11:6] end_reg,
                                   // [21:12] saved_mask
);

    logic                             in_valid_reg;
    rpa_pkg::opcode_t                 in_op_reg;
    logic [3:0]                       in_len_reg;
    logic [4:0]                       in_rel_reg;

    logic                             out_valid_reg;
    rpa_pkg::result_t                 out_reg;
    rpa_pkg::result_t                 out_next;

    logic [rpa_pkg::NUM_REGS-1:0]     busy_reg;
    logic [rpa_pkg::NUM_REGS-1:0]     busy_next;
    logic [rpa_pkg::SAVED_W-1:0]      marks_reg;
    logic [rpa_pkg::SAVED_W-1:0]      marks_next;

    logic                             out_ready;
    logic                             process;

    logic [3:0]                       req_len;
    logic                             len_ok;
    logic [rpa_pkg::NUM_REGS-1:0]     len_mask;
    logic [rpa_pkg::NUM_REGS-1:0]     fit;
    logic [4:0]                       sel;
    logic                             found;
    logic [rpa_pkg::NUM_REGS-1:0]     alloc_mask;
    logic [rpa_pkg::NUM_REGS-1:0]     rel_bit;

    assign out_ready = !out_valid_reg || m_tready;
    assign process   = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;

    // Input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_op_reg  <= rpa_pkg::opcode_t'(s_tdata[1:0]);
            in_len_reg <= s_tdata[5:2];
            in_rel_reg <= s_tdata[10:6];
        end
    end

    // Candidate starts: every pool position where the whole run is free and stays in pool
    always_comb begin
        req_len  = (in_op_reg == rpa_pkg::OP_ALLOC_ONE) ? 4'd1 : in_len_reg;
        len_ok   = (req_len != 4'd0) && (req_len <= 4'(rpa_pkg::MAX_RUN));
        len_mask = 32'((33'd1 << req_len) - 33'd1);
        for (int i = 0; i < rpa_pkg::NUM_REGS; i++) begin
            fit[i] = rpa_pkg::POOL_MASK[i]
                  && ((busy_reg & (len_mask << i)) == '0)
                  && ((6'(i) + {2'b00, req_len}) <=
                      (rpa_pkg::POOL1_MASK[i] ? rpa_pkg::POOL1_END : rpa_pkg::POOL2_END));
        end
        // Scratch pool sits below the callee-saved one, so lowest start is first fit
        sel = '0;
        for (int i = rpa_pkg::NUM_REGS - 1; i >= 0; i--) begin
            if (fit[i]) begin
                sel = 5'(i);
            end
        end
        found      = len_ok && (fit != '0);
        alloc_mask = len_mask << sel;
        rel_bit    = 32'd1 << in_rel_reg;
    end

    always_comb begin
        busy_next           = busy_reg;
        marks_next          = marks_reg;
        out_next.status     = 1'b0;
        out_next.first_reg  = '0;
        out_next.end_reg    = '0;
        case (in_op_reg)
            rpa_pkg::OP_ALLOC_ONE, rpa_pkg::OP_ALLOC_RUN: begin
                if (found) begin
                    busy_next          = busy_reg | alloc_mask;
                    marks_next         = marks_reg | alloc_mask[28:19];
                    out_next.first_reg = sel;
                    out_next.end_reg   = {1'b0, sel} + {2'b00, req_len};
                end else begin
                    out_next.status = 1'b1;
                end
            end
            rpa_pkg::OP_RELEASE: begin
                busy_next = busy_reg & ~(rel_bit & rpa_pkg::POOL_MASK);
            end
            rpa_pkg::OP_RELEASE_ALL: begin
                busy_next = busy_reg & ~rpa_pkg::POOL_MASK;
            end
            default: begin
                busy_next = busy_reg;
            end
        endcase
        out_next.saved_mask = marks_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= '0;
            marks_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (process) begin
                busy_reg  <= busy_next;
                marks_reg <= marks_next;
            end
            if (out_ready) begin
                out_valid_reg <= in_valid_reg;
            end
        end
        if (process) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg};

    // Nothing outside the two pools is ever marked busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg & ~rpa_pkg::POOL_MASK) == '0)
        else $error("busy bit set outside the pools");

    // Callee-saved marks are sticky
    assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> ((marks_reg & $past(marks_reg)) == $past(marks_reg)))
        else $error("callee-saved mark cleared");

    // A granted run is non-empty and no longer than the limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.end_reg != '0) |->
            (out_reg.end_reg > {1'b0, out_reg.first_reg}) &&
            ((out_reg.end_reg - {1'b0, out_reg.first_reg}) <= 6'(rpa_pkg::MAX_RUN)))
        else $error("granted run length out of range");

    // A failed allocation reports no registers
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.status) |-> (out_reg.first_reg == '0 && out_reg.end_reg == '0))
        else $error("failed allocation reports registers");

    // A granted run ends inside the pool it started in
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.end_reg != '0) |->
            ((out_reg.first_reg >= 5'd9 && out_reg.end_reg <= rpa_pkg::POOL1_END) ||
             (out_reg.first_reg >= 5'd19 && out_reg.end_reg <= rpa_pkg::POOL2_END)))
        else $error("granted run leaves its pool");

endmodule

@@ test/register_pool_allocator_top_tb.sv @@
`timescale 1ns / 1ps

module register_pool_allocator_top_tb;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned RANDOM_ITEMS = 1000;
    localparam int unsigned IDLE_PCT     = 31;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;

    bit          no_idle = 1'b0;
    int unsigned cycle_count = 0;

    register_pool_allocator_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Mirrors the busy map and callee-saved marks, keeps the results still owed
    class allocation_tracker;
        bit [rpa_pkg::NUM_REGS-1:0] busy_map;
        bit [rpa_pkg::SAVED_W-1:0]  callee_marks;
        rpa_pkg::result_t           grant_q[$];
        int                         errors;

        function new();
            busy_map     = '0;
            callee_marks = '0;
            errors       = 0;
        endfunction

        // lowest start in [lo, stop) with n free registers ending at or before stop
        function int find_free_run(int lo, int stop, int n);
            logic [rpa_pkg::NUM_REGS-1:0] m;
            for (int s = lo; s + n <= stop; s++) begin
                m = 32'(((64'd1 << n) - 64'd1) << s);
                if ((busy_map & m) == '0)
                    return s;
            end
            return stop;
        endfunction

        function void note_request(rpa_pkg::opcode_t op, logic [3:0] len, logic [4:0] rel);
            rpa_pkg::result_t             r;
            int                           n;
            int                           s;
            logic [rpa_pkg::NUM_REGS-1:0] m;
            r = '0;
            case (op)
                rpa_pkg::OP_ALLOC_ONE, rpa_pkg::OP_ALLOC_RUN: begin
                    n = (op == rpa_pkg::OP_ALLOC_ONE) ? 1 : int'(len);
                    r.status = 1'b1;
                    if (n >= 1 && n <= int'(rpa_pkg::MAX_RUN)) begin
                        s = find_free_run(int'(rpa_pkg::POOL1_LO), int'(rpa_pkg::POOL1_END), n);
                        if (s == int'(rpa_pkg::POOL1_END))
                            s = find_free_run(int'(rpa_pkg::POOL2_LO),
                                              int'(rpa_pkg::POOL2_END), n);
                        if (s != int'(rpa_pkg::POOL2_END)) begin
                            m = 32'(((64'd1 << n) - 64'd1) << s);
                            busy_map |= m;
                            if (s >= int'(rpa_pkg::POOL2_LO))
                                callee_marks |= m[28:19];
                            r.status    = 1'b0;
                            r.first_reg = 5'(s);
                            r.end_reg   = 6'(s + n);
                        end
                    end
                end
                rpa_pkg::OP_RELEASE: begin
                    if (rpa_pkg::POOL_MASK[rel])
                        busy_map[rel] = 1'b0;
                end
                default: begin
                    busy_map &= ~rpa_pkg::POOL_MASK;
                end
            endcase
            r.saved_mask = callee_marks;
            grant_q.push_back(r);
        endfunction

        function void check_result(logic [23:0] data);
            rpa_pkg::result_t got;
            rpa_pkg::result_t want;
            got = rpa_pkg::result_t'(data[21:0]);
            if (grant_q.size() == 0) begin
                $error("result transaction with nothing outstanding: %h", data);
                errors++;
                return;
            end
            want = grant_q.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.first_reg !== want.first_reg) begin
                $error("first_reg: expected %0d, got %0d", want.first_reg, got.first_reg);
                errors++;
            end
            if (got.end_reg !== want.end_reg) begin
                $error("end_reg: expected %0d, got %0d", want.end_reg, got.end_reg);
                errors++;
            end
            if (got.saved_mask !== want.saved_mask) begin
                $error("saved_mask: expected %h, got %h", want.saved_mask, got.saved_mask);
                errors++;
            end
        endfunction
    endclass

    allocation_tracker tracker;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("register_pool_allocator_top test failed");
                $finish;
            end
        end
    end

    // result side: random back-pressure
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready)
                tracker.check_result(m_tdata);
        end
    end

    task automatic send_request(rpa_pkg::opcode_t op, logic [3:0] len, logic [4:0] rel);
        @(negedge aclk);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, rel, len, op};
        do
            @(posedge aclk);
        while (!s_tready);
        tracker.note_request(op, len, rel);
    endtask

    task automatic send_random_request();
        int unsigned      pick;
        rpa_pkg::opcode_t op;
        logic [3:0]       len;
        logic [4:0]       rel;
        pick = $urandom_range(99);
        len  = 4'($urandom_range(15));
        rel  = 5'($urandom_range(31));
        if (pick < 36) begin
            op = rpa_pkg::OP_ALLOC_ONE;
        end else if (pick < 66) begin
            op = rpa_pkg::OP_ALLOC_RUN;
            if ($urandom_range(9) != 0)
                len = 4'($urandom_range(rpa_pkg::MAX_RUN, 1));
        end else if (pick < 97) begin
            op = rpa_pkg::OP_RELEASE;
            // mostly hit pool registers so the map drains
            if ($urandom_range(4) != 0)
                rel = $urandom_range(1) ? 5'($urandom_range(15, 9))
                                        : 5'($urandom_range(28, 19));
        end else begin
            op = rpa_pkg::OP_RELEASE_ALL;
        end
        send_request(op, len, rel);
    endtask

    initial begin
        tracker  = new();
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // fill the scratch pool, spill into the callee-saved pool
        repeat (8) send_request(rpa_pkg::OP_ALLOC_ONE, 4'd0, 5'd0);
        send_request(rpa_pkg::OP_ALLOC_RUN, 4'd0, 5'd31);
        send_request(rpa_pkg::OP_ALLOC_RUN, 4'd9, 5'd0);
        send_request(rpa_pkg::OP_ALLOC_RUN, 4'd15, 5'd0);
        send_request(rpa_pkg::OP_ALLOC_RUN, 4'd8, 5'd0);
        // only register 28 left: a run of two must not spill past it
        send_request(rpa_pkg::OP_ALLOC_RUN, 4'd2, 5'd0);
        send_request(rpa_pkg::OP_RELEASE, 4'd0, 5'd0);
        send_request(rpa_pkg::OP_RELEASE, 4'd15, 5'd31);
        send_request(rpa_pkg::OP_RELEASE, 4'd0, 5'd16);
        send_request(rpa_pkg::OP_RELEASE, 4'd0, 5'd9);
        send_request(rpa_pkg::OP_RELEASE, 4'd0, 5'd19);
        send_request(rpa_pkg::OP_ALLOC_RUN, 4'd1, 5'd0);
        send_request(rpa_pkg::OP_ALLOC_ONE, 4'd0, 5'd0);
        send_request(rpa_pkg::OP_RELEASE_ALL, 4'd15, 5'd31);
        send_request(rpa_pkg::OP_ALLOC_RUN, 4'd8, 5'd0);
        send_request(rpa_pkg::OP_ALLOC_RUN, 4'd7, 5'd0);
        send_request(rpa_pkg::OP_ALLOC_RUN, 4'd3, 5'd0);
        send_request(rpa_pkg::OP_ALLOC_RUN, 4'd2, 5'd0);
        send_request(rpa_pkg::OP_RELEASE_ALL, 4'd0, 5'd0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            no_idle = (i >= 400 && i < 600);
            send_random_request();
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;
        no_idle = 1'b0;

        while (tracker.grant_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);

        if (tracker.errors == 0)
            $display("register_pool_allocator_top test passed");
        else
            $display("register_pool_allocator_top test failed");
        $finish;
    end

endmodule
